[hw/rtl/pss_pkg.sv]
package pss_pkg;

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int ID_W    = 5;
    localparam int WAIT_W  = 20;
    localparam int TOTW_W  = 23;
    localparam int TOTT_W  = 24;

    // One stored process
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } t_entry;

    // Pop request from the sorter chain to the result stage
    typedef struct packed {
        logic pop;
        logic final_res;
        logic overflow;
    } t_emit_ctl;

    // True if process a is served before b; equal keys keep arrival order
    function automatic logic goes_first(input t_entry a, input t_entry b);
        logic res;
        if (a.prio != b.prio) begin
            res = (a.prio < b.prio);
        end else begin
            res = (a.burst > b.burst);
        end
        return res;
    endfunction

endpackage

[hw/rtl/pss_cell.sv]
module pss_cell (
    input  logic            i_clk,
    input  pss_pkg::t_entry i_new,
    input  pss_pkg::t_entry i_prev,
    input  pss_pkg::t_entry i_next,
    input  logic            i_vld,
    input  logic            i_load,
    input  logic            i_pop,
    input  logic            i_prev_ins,
    output logic            o_ins,
    output pss_pkg::t_entry o_entry
);
    import pss_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // New request belongs at or above this slot
    assign o_ins = !i_vld || goes_first(i_new, r_entry);

    // Shift toward the tail on insert, toward the head on pop
    always_comb begin
        n_entry = r_entry;
        priority if (i_pop) begin
            n_entry = i_next;
        end else if (i_load) begin
            priority if (i_prev_ins) begin
                n_entry = i_prev;
            end else if (o_ins) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[hw/rtl/pss_emit.sv]
module pss_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pss_pkg::t_entry             i_head,
    input  pss_pkg::t_emit_ctl          i_ctl,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [pss_pkg::ID_W-1:0]    o_proc_id,
    output logic [pss_pkg::BURST_W-1:0] o_burst_out,
    output logic [pss_pkg::PRIO_W-1:0]  o_prio_out,
    output logic [pss_pkg::WAIT_W-1:0]  o_wait_time,
    output logic [pss_pkg::WAIT_W-1:0]  o_turnaround,
    output logic [pss_pkg::TOTW_W-1:0]  o_total_wait,
    output logic [pss_pkg::TOTT_W-1:0]  o_total_turnaround,
    output logic                        o_final_res,
    output logic                        o_overflow
);
    import pss_pkg::*;

    logic              r_valid;
    logic [TOTT_W-1:0] r_clock;
    logic [TOTW_W-1:0] r_tot_w;
    logic [TOTT_W-1:0] r_tot_t;
    t_entry            r_res;
    logic [WAIT_W-1:0] r_wait;
    logic [WAIT_W-1:0] r_tat;
    logic [TOTW_W-1:0] r_out_tw;
    logic [TOTT_W-1:0] r_out_tt;
    logic              r_final;
    logic              r_ovf;

    logic [TOTT_W-1:0] w_clk_next;
    logic [WAIT_W-1:0] w_tat;
    logic [TOTW_W-1:0] w_tot_w;
    logic [TOTT_W-1:0] w_tot_t;

    // Running sums for the head process; keep the clock as wide as the totals
    assign w_clk_next = r_clock + TOTT_W'(i_head.burst);
    assign w_tat      = w_clk_next[WAIT_W-1:0];
    assign w_tot_w    = r_tot_w + r_clock[TOTW_W-1:0];
    assign w_tot_t    = r_tot_t + w_clk_next;

    // Output valid and schedule accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_clock <= '0;
            r_tot_w <= '0;
            r_tot_t <= '0;
        end else if (i_ctl.pop) begin
            r_valid <= 1'b1;
            if (i_ctl.final_res) begin
                r_clock <= '0;
                r_tot_w <= '0;
                r_tot_t <= '0;
            end else begin
                r_clock <= w_clk_next;
                r_tot_w <= w_tot_w;
                r_tot_t <= w_tot_t;
            end
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_res    <= i_head;
            r_wait   <= r_clock[WAIT_W-1:0];
            r_tat    <= w_tat;
            r_out_tw <= i_ctl.final_res ? w_tot_w : '0;
            r_out_tt <= i_ctl.final_res ? w_tot_t : '0;
            r_final  <= i_ctl.final_res;
            r_ovf    <= i_ctl.overflow;
        end
    end

    assign o_valid            = r_valid;
    assign o_proc_id          = r_res.id;
    assign o_burst_out        = r_res.burst;
    assign o_prio_out         = r_res.prio;
    assign o_wait_time        = r_wait;
    assign o_turnaround       = r_tat;
    assign o_total_wait       = r_out_tw;
    assign o_total_turnaround = r_out_tt;
    assign o_final_res        = r_final;
    assign o_overflow         = r_ovf;

endmodule

[hw/rtl/priority_schedule_sorter.sv]
// Nonpreemptive priority scheduler. Processes arrive one request per cycle
// (burst, priority, last) and drop straight into their place in a chain of
// MAX_PROCS sorting cells, ordered by ascending priority, then longer burst
// first, then arrival order; each gets an id of 1 and up in arrival order.
// The request flagged last closes the batch and the chain then shifts out
// one result per cycle toward the output register (waiting time,
// turnaround, and totals on the final result) while the consumer does not
// stall. No requests are taken while the chain drains; the next batch may
// start as soon as the final result sits in the output register.
// Requests past MAX_PROCS are dropped and set overflow on every result of
// that batch.
module priority_schedule_sorter #(
    parameter int MAX_PROCS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pss_pkg::BURST_W-1:0] i_burst,
    input  logic [pss_pkg::PRIO_W-1:0]  i_prio,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pss_pkg::ID_W-1:0]    o_proc_id,
    output logic [pss_pkg::BURST_W-1:0] o_burst_out,
    output logic [pss_pkg::PRIO_W-1:0]  o_prio_out,
    output logic [pss_pkg::WAIT_W-1:0]  o_wait_time,
    output logic [pss_pkg::WAIT_W-1:0]  o_turnaround,
    output logic [pss_pkg::TOTW_W-1:0]  o_total_wait,
    output logic [pss_pkg::TOTT_W-1:0]  o_total_turnaround,
    output logic                        o_final_res,
    output logic                        o_overflow
);
    import pss_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_drop;
    logic             n_drop;

    logic             w_load;
    logic             w_store;
    logic             w_full;
    logic             w_pop;
    logic             w_done;
    t_entry           w_new;
    t_emit_ctl        w_ctl;

    t_entry           w_entry [MAX_PROCS];
    logic             w_ins   [MAX_PROCS];

    assign o_ready = (r_state == ST_LOAD);
    assign w_load  = i_valid && o_ready;
    assign w_full  = (r_count == CNT_W'(MAX_PROCS));
    assign w_store = w_load && !w_full;
    assign w_pop   = (r_state == ST_EMIT) && (!o_valid || i_ready);
    assign w_done  = w_pop && (r_count == CNT_W'(1));

    // Incoming process with its arrival id
    assign w_new.prio  = i_prio;
    assign w_new.burst = i_burst;
    assign w_new.id    = ID_W'({1'b0, r_count} + (CNT_W + 1)'(1));

    // Sorting chain
    for (genvar gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_ins;

        if (gi == 0) begin : g_head
            assign w_prev     = w_new;
            assign w_prev_ins = 1'b0;
        end else begin : g_body
            assign w_prev     = w_entry[gi-1];
            assign w_prev_ins = w_ins[gi-1];
        end

        if (gi == MAX_PROCS - 1) begin : g_tail
            assign w_next = w_entry[gi];
        end else begin : g_link
            assign w_next = w_entry[gi+1];
        end

        pss_cell u_cell (
            .i_clk      (i_clk),
            .i_new      (w_new),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .i_vld      (CNT_W'(gi) < r_count),
            .i_load     (w_store),
            .i_pop      (w_pop),
            .i_prev_ins (w_prev_ins),
            .o_ins      (w_ins[gi]),
            .o_entry    (w_entry[gi])
        );
    end

    // Batch control: load, drop when full, drain on close
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        unique case (r_state)
            ST_LOAD: begin
                if (w_load) begin
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_pop) begin
                    n_count = r_count - CNT_W'(1);
                    if (w_done) begin
                        n_state = ST_LOAD;
                        n_drop  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    assign w_ctl.pop       = w_pop;
    assign w_ctl.final_res = w_done;
    assign w_ctl.overflow  = r_drop;

    pss_emit u_emit (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (w_entry[0]),
        .i_ctl              (w_ctl),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_proc_id          (o_proc_id),
        .o_burst_out        (o_burst_out),
        .o_prio_out         (o_prio_out),
        .o_wait_time        (o_wait_time),
        .o_turnaround       (o_turnaround),
        .o_total_wait       (o_total_wait),
        .o_total_turnaround (o_total_turnaround),
        .o_final_res        (o_final_res),
        .o_overflow         (o_overflow)
    );

endmodule

[hw/rtl/pss_checker.sv]
module pss_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic [pss_pkg::BURST_W-1:0] i_burst,
    input  logic [pss_pkg::PRIO_W-1:0]  i_prio,
    input  logic                        i_last,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [pss_pkg::ID_W-1:0]    o_proc_id,
    input  logic [pss_pkg::BURST_W-1:0] o_burst_out,
    input  logic [pss_pkg::PRIO_W-1:0]  o_prio_out,
    input  logic [pss_pkg::WAIT_W-1:0]  o_wait_time,
    input  logic [pss_pkg::WAIT_W-1:0]  o_turnaround,
    input  logic [pss_pkg::TOTW_W-1:0]  o_total_wait,
    input  logic [pss_pkg::TOTT_W-1:0]  o_total_turnaround,
    input  logic                        o_final_res,
    input  logic                        o_overflow
);
    import pss_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_proc_id) && $stable(o_wait_time))
        else $error("result changed while stalled");

    // Totals appear only on the final result
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_res |-> o_total_wait == '0 && o_total_turnaround == '0)
        else $error("totals on a non-final result");

    // Turnaround is waiting time plus own burst
    a_tat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_turnaround == WAIT_W'(o_wait_time + WAIT_W'(o_burst_out)))
        else $error("turnaround mismatch");

    // No new request taken while a batch is still draining
    a_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_res |-> !o_ready)
        else $error("request accepted during drain");

endmodule

bind priority_schedule_sorter pss_checker u_pss_checker (.*);

[tb/sched_checker.sv]
`timescale 1ns / 100ps
module sched_checker #(
    parameter int MAX_PROCS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic [pss_pkg::BURST_W-1:0] i_burst,
    input  logic [pss_pkg::PRIO_W-1:0]  i_prio,
    input  logic                        i_last,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic [pss_pkg::ID_W-1:0]    i_proc_id,
    input  logic [pss_pkg::BURST_W-1:0] i_burst_out,
    input  logic [pss_pkg::PRIO_W-1:0]  i_prio_out,
    input  logic [pss_pkg::WAIT_W-1:0]  i_wait_time,
    input  logic [pss_pkg::WAIT_W-1:0]  i_turnaround,
    input  logic [pss_pkg::TOTW_W-1:0]  i_total_wait,
    input  logic [pss_pkg::TOTT_W-1:0]  i_total_turnaround,
    input  logic                        i_final_res,
    input  logic                        i_overflow,
    output int                          o_fail_count,
    output int                          o_pending
);
    import pss_pkg::*;

    // One scheduled process as it should leave the block
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [WAIT_W-1:0]  wait_time;
        logic [WAIT_W-1:0]  turnaround;
        logic [TOTW_W-1:0]  tot_wait;
        logic [TOTT_W-1:0]  tot_turn;
        logic               fin;
        logic               ovf;
    } t_service;

    logic [BURST_W-1:0] slot_burst [MAX_PROCS];
    logic [PRIO_W-1:0]  slot_prio  [MAX_PROCS];
    logic [ID_W-1:0]    slot_id    [MAX_PROCS];
    int                 slot_count;
    logic               dropped;
    t_service           service_q [$];

    // Lower priority number first, then longer burst, then earlier arrival
    function automatic logic serve_before(input int a, input int b);
        if (slot_prio[a] != slot_prio[b])
            return slot_prio[a] < slot_prio[b];
        if (slot_burst[a] != slot_burst[b])
            return slot_burst[a] > slot_burst[b];
        return slot_id[a] < slot_id[b];
    endfunction

    // Order the batch, queue one service record per process, clear the store
    task automatic schedule_batch();
        int          order [MAX_PROCS];
        int          i;
        int          k;
        int          t;
        logic [23:0] clock_sum;
        logic [23:0] wait_sum;
        logic [23:0] turn_sum;
        logic [23:0] turn_one;
        t_service    rec;
        for (i = 0; i < slot_count; i++)
            order[i] = i;
        for (i = 1; i < slot_count; i++) begin
            t = order[i];
            k = i;
            while (k > 0 && serve_before(t, order[k-1])) begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = t;
        end
        clock_sum = '0;
        wait_sum  = '0;
        turn_sum  = '0;
        for (i = 0; i < slot_count; i++) begin
            t = order[i];
            turn_one = clock_sum + 24'(slot_burst[t]);
            wait_sum += clock_sum;
            turn_sum += turn_one;
            rec.id         = slot_id[t];
            rec.burst      = slot_burst[t];
            rec.prio       = slot_prio[t];
            rec.wait_time  = clock_sum[WAIT_W-1:0];
            rec.turnaround = turn_one[WAIT_W-1:0];
            rec.fin        = (i == slot_count - 1);
            rec.ovf        = dropped;
            rec.tot_wait   = rec.fin ? wait_sum[TOTW_W-1:0] : '0;
            rec.tot_turn   = rec.fin ? turn_sum[TOTT_W-1:0] : '0;
            service_q.push_back(rec);
            clock_sum = turn_one;
        end
        slot_count = 0;
        dropped    = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
        if (exp_v !== act_v) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Load requests into the store and compare results against the schedule
    always @(posedge i_clk) begin : watch
        t_service want;
        if (!i_rst_n) begin
            slot_count   = 0;
            dropped      = 1'b0;
            o_fail_count = 0;
            service_q.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                if (slot_count < MAX_PROCS) begin
                    slot_burst[slot_count] = i_burst;
                    slot_prio[slot_count]  = i_prio;
                    slot_id[slot_count]    = ID_W'(slot_count + 1);
                    slot_count++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_last)
                    schedule_batch();
            end
            if (i_res_valid && i_res_ready) begin
                if (service_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, got id %0d",
                             $time, i_proc_id);
                end else begin
                    want = service_q.pop_front();
                    check_field("proc_id", 24'(want.id), 24'(i_proc_id));
                    check_field("burst_out", 24'(want.burst), 24'(i_burst_out));
                    check_field("prio_out", 24'(want.prio), 24'(i_prio_out));
                    check_field("wait_time", 24'(want.wait_time), 24'(i_wait_time));
                    check_field("turnaround", 24'(want.turnaround), 24'(i_turnaround));
                    check_field("total_wait", 24'(want.tot_wait), 24'(i_total_wait));
                    check_field("total_turnaround", want.tot_turn, i_total_turnaround);
                    check_field("final_res", 24'(want.fin), 24'(i_final_res));
                    check_field("overflow", 24'(want.ovf), 24'(i_overflow));
                end
            end
        end
        o_pending <= service_q.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
    import pss_pkg::*;

    localparam int MAX_PROCS   = 16;
    localparam int N_ITEMS     = 430;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [BURST_W-1:0] i_burst;
    logic [PRIO_W-1:0]  i_prio;
    logic               i_last;
    logic               o_valid;
    logic               i_ready;
    logic [ID_W-1:0]    o_proc_id;
    logic [BURST_W-1:0] o_burst_out;
    logic [PRIO_W-1:0]  o_prio_out;
    logic [WAIT_W-1:0]  o_wait_time;
    logic [WAIT_W-1:0]  o_turnaround;
    logic [TOTW_W-1:0]  o_total_wait;
    logic [TOTT_W-1:0]  o_total_turnaround;
    logic               o_final_res;
    logic               o_overflow;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int sent_count  = 0;
    bit fast_tx;
    bit fast_rx;
    bit rx_hold_req;

    priority_schedule_sorter #(
        .MAX_PROCS(MAX_PROCS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_burst            (i_burst),
        .i_prio             (i_prio),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_proc_id          (o_proc_id),
        .o_burst_out        (o_burst_out),
        .o_prio_out         (o_prio_out),
        .o_wait_time        (o_wait_time),
        .o_turnaround       (o_turnaround),
        .o_total_wait       (o_total_wait),
        .o_total_turnaround (o_total_turnaround),
        .o_final_res        (o_final_res),
        .o_overflow         (o_overflow)
    );

    sched_checker #(
        .MAX_PROCS(MAX_PROCS)
    ) u_sched_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_ready        (o_ready),
        .i_burst            (i_burst),
        .i_prio             (i_prio),
        .i_last             (i_last),
        .i_res_valid        (o_valid),
        .i_res_ready        (i_ready),
        .i_proc_id          (o_proc_id),
        .i_burst_out        (o_burst_out),
        .i_prio_out         (o_prio_out),
        .i_wait_time        (o_wait_time),
        .i_turnaround       (o_turnaround),
        .i_total_wait       (o_total_wait),
        .i_total_turnaround (o_total_turnaround),
        .i_final_res        (o_final_res),
        .i_overflow         (o_overflow),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request, idling a random number of cycles first unless fast_tx is set
    task automatic send_req(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
                            input logic l);
        int gap;
        gap = fast_tx ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_burst <= b;
        i_prio  <= p;
        i_last  <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_count++;
    endtask

    // Hold off new requests until every scheduled result has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Result side: random stalls, stretches of none, one long hold on request
    initial begin : rx_side
        int gap;
        int n_seen;
        bit hold_done;
        i_ready <= 1'b0;
        n_seen = 0;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (n_seen % 20 == 0)
                fast_rx = ($urandom_range(0, 2) == 0);
            gap = fast_rx ? 0 : $urandom_range(0, 17);
            if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                gap = LONG_HOLD;
            end
            if (gap == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_ready <= 1'b1;
            end
            @(posedge i_clk);
            while (!(o_valid && i_ready)) @(posedge i_clk);
            n_seen++;
        end
    end

    initial begin : tx_side
        int                 size;
        int                 pick;
        int                 prio_hi;
        int                 burst_mode;
        int                 batch_idx;
        int                 k;
        logic [BURST_W-1:0] bv;
        logic [PRIO_W-1:0]  pv;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_burst     <= '0;
        i_prio      <= '0;
        i_last      <= 1'b0;
        fast_tx     = 1'b0;
        rx_hold_req = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-process batch at the field maxima
        send_req(16'hFFFF, 8'hFF, 1'b1);
        // ties on priority, on burst, and on both keys; zero burst
        send_req(16'd0, 8'd0, 1'b0);
        send_req(16'hFFFF, 8'd0, 1'b0);
        send_req(16'd100, 8'd7, 1'b0);
        send_req(16'd100, 8'd7, 1'b0);
        send_req(16'd100, 8'd3, 1'b1);
        // fill the store with the longest bursts, then overflow; drop the closing request
        for (k = 0; k < MAX_PROCS + 2; k++) begin
            pv = PRIO_W'($urandom_range(0, 3));
            send_req(16'hFFFF, pv, k == MAX_PROCS + 1);
        end
        drain_results();

        // random batches: mostly fitting, some full, some overflowing
        batch_idx = 0;
        while (sent_count < N_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                size = MAX_PROCS;
            else if (pick == 1)
                size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
            else
                size = $urandom_range(1, 12);
            prio_hi    = ($urandom_range(0, 1) == 0) ? 3 : 255;
            burst_mode = $urandom_range(0, 2);
            fast_tx    = ($urandom_range(0, 3) == 0);
            // stall the result side for a long stretch while requests keep coming
            if (batch_idx == 3)
                rx_hold_req = 1'b1;
            for (k = 0; k < size; k++) begin
                case (burst_mode)
                    0:       bv = BURST_W'($urandom_range(0, 65535));
                    1:       bv = BURST_W'($urandom_range(0, 7));
                    default: bv = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                endcase
                pv = PRIO_W'($urandom_range(0, prio_hi));
                send_req(bv, pv, k == size - 1);
            end
            batch_idx++;
            if (batch_idx % 8 == 0)
                drain_results();
        end
        drain_results();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
